### src/lcr_pkg.sv
// Shared types and constants for the link command responder.
// No dependencies; imported by every module of the block.
package lcr_pkg;

  // Frame and payload lengths, index width
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] FRAME_LEN = 6'd42;
  localparam logic [IDX_W-1:0] WRITE_LEN = 6'd24;

  // Payload offsets that carry clock fields
  localparam logic [IDX_W-1:0] CAP_FIRST = 6'd8;
  localparam logic [IDX_W-1:0] CAP_LAST  = 6'd12;
  localparam logic [IDX_W-1:0] CAP_YEAR  = 6'd21;

  // Command and reply codes
  localparam logic [7:0] CMD_INIT   = 8'h52;
  localparam logic [7:0] CMD_POLL   = 8'h4F;
  localparam logic [7:0] CMD_READ   = 8'h44;
  localparam logic [7:0] CMD_WRITE  = 8'h57;
  localparam logic [7:0] INIT_REPLY = 8'h44;
  localparam logic [7:0] WRITE_ACK  = 8'h30;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // Input item kinds
  localparam logic [1:0] KIND_LINK = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Clock limits and reset values
  localparam logic [7:0] SEC_LIMIT   = 8'd60;
  localparam logic [7:0] MIN_LIMIT   = 8'd60;
  localparam logic [7:0] HOUR_LIMIT  = 8'd24;
  localparam logic [7:0] DAY_MASK    = 8'h3F;
  localparam logic [7:0] MONTH_MASK  = 8'h1F;
  localparam logic [7:0] DAY_RESET   = 8'd1;
  localparam logic [7:0] MONTH_RESET = 8'd1;
  localparam logic [7:0] YEAR_RESET  = 8'd126;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ACTIVE,
    MODE_READ,
    MODE_WRITE
  } mode_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } clock_time_t;

  // Load request from a finished clock write; fields hold raw payload bytes
  typedef struct packed {
    logic        valid;
    clock_time_t raw;
  } clock_load_t;

endpackage

### src/lcr_clock.sv
// Software clock: seconds, minutes, hours and the fixed date fields.
// Depends on lcr_pkg for the time types and limits.
module lcr_clock (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  lcr_pkg::clock_load_t load,
  output lcr_pkg::clock_time_t now
);
  import lcr_pkg::*;

  clock_time_t now_next;
  logic [7:0]  sec_inc;
  logic [7:0]  min_inc;
  logic [7:0]  hour_inc;

  // Decode one BCD byte, letting A..F nibbles count as 10..15
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  assign sec_inc  = now.sec + 8'd1;
  assign min_inc  = now.min + 8'd1;
  assign hour_inc = now.hour + 8'd1;

  // Advance time on a tick; at the end of a write, load decoded fields and the raw year
  always_comb begin
    now_next = now;
    if (load.valid) begin
      now_next.sec   = from_bcd(load.raw.sec);
      now_next.min   = from_bcd(load.raw.min);
      now_next.hour  = from_bcd(load.raw.hour);
      now_next.day   = from_bcd(load.raw.day & DAY_MASK);
      now_next.month = from_bcd(load.raw.month & MONTH_MASK);
      now_next.year  = load.raw.year;
    end else if (tick) begin
      now_next.sec = sec_inc;
      if (sec_inc >= SEC_LIMIT) begin
        now_next.sec = 8'd0;
        now_next.min = min_inc;
        if (min_inc >= MIN_LIMIT) begin
          now_next.min  = 8'd0;
          now_next.hour = (hour_inc >= HOUR_LIMIT) ? 8'd0 : hour_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now.sec   <= 8'd0;
      now.min   <= 8'd0;
      now.hour  <= 8'd0;
      now.day   <= DAY_RESET;
      now.month <= MONTH_RESET;
      now.year  <= YEAR_RESET;
    end else begin
      now <= now_next;
    end
  end

endmodule

### src/lcr_frame.sv
// Clock read frame formatter: ASCII byte at one frame offset.
// Depends on lcr_pkg for the snapshot type and ASCII constants.
module lcr_frame (
  input  lcr_pkg::clock_time_t snap,
  input  logic [lcr_pkg::IDX_W-1:0] pos,
  output logic [7:0]          data
);
  import lcr_pkg::*;

  localparam logic [IDX_W-1:0] DIGIT_FIRST = 6'd4;
  localparam logic [IDX_W-1:0] DIGIT_LAST  = 6'd13;
  localparam logic [IDX_W-1:0] YEAR_HI_POS = 6'h1E;
  localparam logic [IDX_W-1:0] YEAR_LO_POS = 6'h1F;

  logic [IDX_W-1:0] rel;
  logic [2:0]       sel;
  logic [7:0]       v;
  logic [15:0]      prod;
  logic [4:0]       quot;
  logic [4:0]       tens;
  logic [7:0]       units;

  assign rel = pos - DIGIT_FIRST;
  assign sel = rel[3:1];

  // Pick the field for this digit pair
  always_comb begin
    unique case (sel)
      3'd0:    v = snap.sec;
      3'd1:    v = snap.min;
      3'd2:    v = snap.hour;
      3'd3:    v = snap.day;
      3'd4:    v = snap.month;
      default: v = snap.year;
    endcase
  end

  // Split into decimal digits: divide by ten through the reciprocal 205/2048
  assign prod  = {8'd0, v} * 16'd205;
  assign quot  = prod[15:11];
  assign tens  = (quot >= 5'd20) ? quot - 5'd20 :
                 (quot >= 5'd10) ? quot - 5'd10 : quot;
  assign units = v - (({3'd0, quot} << 3) + ({3'd0, quot} << 1));

  // Place digits, year nibbles or filler
  always_comb begin
    data = ASCII_ZERO;
    if (pos >= DIGIT_FIRST && pos <= DIGIT_LAST) begin
      if (!rel[0]) data = ASCII_ZERO + {3'd0, tens};
      else         data = ASCII_ZERO + {4'd0, units[3:0]};
    end else if (pos == YEAR_HI_POS) begin
      data = ASCII_ZERO + {4'd0, snap.year[7:4]};
    end else if (pos == YEAR_LO_POS) begin
      data = ASCII_ZERO + {4'd0, snap.year[3:0]};
    end
  end

endmodule

### src/link_command_responder_with_clock.sv
// Link command responder with software clock: top level.
// Each accepted link byte's response is registered in response_byte.
// Throughput: one item per cycle; input stalls only while a response waits untaken.
// Key presses, ticks and unknown kinds give no response; only nonzero keys and ticks update state.
// Reset (rst, synchronous): idle mode, nothing pending, clock 00:00:00 day 1 month 1.
// Depends on lcr_pkg, lcr_clock and lcr_frame.
module link_command_responder_with_clock (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] link_byte,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] response_byte
);
  import lcr_pkg::*;

  mode_t            mode;
  mode_t            mode_next;
  logic [7:0]       no_key_code;
  logic [7:0]       last_key;
  logic             key_pending;
  logic             key_pending_next;
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] byte_index_next;
  logic [IDX_W-1:0] idx_inc;
  logic [7:0]       write_capture [6];
  logic [7:0]       write_capture_next [6];
  clock_time_t      frame_time;
  clock_time_t      now;
  clock_load_t      load;
  logic             accept;
  logic             link_in;
  logic             snap_take;
  logic [7:0]       resp;
  logic [7:0]       frame_data;
  logic [2:0]       cap_sel;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign link_in  = accept && (kind == KIND_LINK);
  assign idx_inc  = byte_index + 6'd1;
  assign cap_sel  = 3'(byte_index - CAP_FIRST);

  // Mode sequencing
  always_comb begin
    mode_next = mode;
    if (link_in) begin
      unique case (mode)
        MODE_IDLE: begin
          if (link_byte == CMD_INIT) mode_next = MODE_ACTIVE;
        end
        MODE_ACTIVE: begin
          if (link_byte == CMD_READ)       mode_next = MODE_READ;
          else if (link_byte == CMD_WRITE) mode_next = MODE_WRITE;
        end
        MODE_READ: begin
          if (idx_inc >= FRAME_LEN) mode_next = MODE_ACTIVE;
        end
        MODE_WRITE: begin
          if (idx_inc >= WRITE_LEN) mode_next = MODE_ACTIVE;
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
  end

  // Response byte and per-mode side effects
  always_comb begin
    resp             = no_key_code;
    key_pending_next = key_pending;
    byte_index_next  = byte_index;
    snap_take        = 1'b0;
    unique case (mode)
      MODE_IDLE: begin
        if (link_byte == CMD_INIT) resp = INIT_REPLY;
      end
      MODE_ACTIVE: begin
        if (link_byte == CMD_POLL) begin
          resp             = key_pending ? last_key : no_key_code;
          key_pending_next = 1'b0;
        end else if (link_byte == CMD_READ) begin
          resp            = ASCII_ZERO;
          byte_index_next = 6'd1;
          snap_take       = 1'b1;
        end else if (link_byte == CMD_WRITE) begin
          resp            = WRITE_ACK;
          byte_index_next = 6'd0;
        end else if (link_byte == CMD_INIT) begin
          resp = INIT_REPLY;
        end
      end
      MODE_READ: begin
        resp            = frame_data;
        byte_index_next = idx_inc;
      end
      MODE_WRITE: begin
        byte_index_next = idx_inc;
      end
      default: resp = no_key_code;
    endcase
  end

  // Capture clock fields from the write payload
  always_comb begin
    write_capture_next = write_capture;
    if (link_in && mode == MODE_WRITE) begin
      if (byte_index >= CAP_FIRST && byte_index <= CAP_LAST) begin
        write_capture_next[cap_sel] = link_byte;
      end else if (byte_index == CAP_YEAR) begin
        write_capture_next[5] = link_byte;
      end
    end
  end

  // Apply the payload on its last byte
  assign load.valid     = link_in && (mode == MODE_WRITE) && (idx_inc >= WRITE_LEN);
  assign load.raw.sec   = write_capture_next[0];
  assign load.raw.min   = write_capture_next[1];
  assign load.raw.hour  = write_capture_next[2];
  assign load.raw.day   = write_capture_next[3];
  assign load.raw.month = write_capture_next[4];
  assign load.raw.year  = write_capture_next[5];

  lcr_clock u_clock (
    .clk  (clk),
    .rst  (rst),
    .tick (accept && (kind == KIND_TICK)),
    .load (load),
    .now  (now)
  );

  lcr_frame u_frame (
    .snap (frame_time),
    .pos  (byte_index),
    .data (frame_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      key_pending <= 1'b0;
      last_key    <= 8'd0;
      byte_index  <= '0;
      no_key_code <= 8'd0;
    end else begin
      if (cfg_we) no_key_code <= cfg_wdata;
      if (link_in) begin
        mode        <= mode_next;
        key_pending <= key_pending_next;
        byte_index  <= byte_index_next;
      end else if (accept && kind == KIND_KEY && key_code != 8'd0) begin
        last_key    <= key_code;
        key_pending <= 1'b1;
      end
    end
  end

  // Payload stores: snapshot on read, capture during write
  always_ff @(posedge clk) begin
    if (link_in && snap_take) frame_time <= now;
    write_capture <= write_capture_next;
  end

  // Result register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (link_in) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in) response_byte <= resp;
  end

endmodule

### src/lcr_checker.sv
// Port-level checks for the link command responder, bound to the top level.
// Depends on lcr_pkg for the item kind codes.
module lcr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] response_byte
);
  import lcr_pkg::*;

  // Hold a stalled response
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(response_byte))
    else $error("response changed or dropped while stalled");

  // Accept input whenever the result slot is free or draining
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with a free result slot");

  // Every link transfer yields a response next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_LINK |=> out_valid)
    else $error("link byte gave no response");

  // Other kinds never produce a response
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind != KIND_LINK && (!out_valid || out_ready) |=> !out_valid)
    else $error("response without a link byte");

  // Reset empties the result slot
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind link_command_responder_with_clock lcr_checker u_lcr_checker (.*);

### tb/sv/tb.sv
// Self-checking bench for the link command responder with its software clock.
// Predicts each response byte in SV and compares it on every output transfer.
// Depends on lcr_pkg and link_command_responder_with_clock.
`timescale 1ns / 1ps

module tb;
  import lcr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [5:0] FIELD_FIRST_POS = 6'd4;
  localparam logic [5:0] FIELD_LAST_POS = 6'd13;
  localparam logic [5:0] YEAR_HI_POS = 6'h1E;
  localparam logic [5:0] YEAR_LO_POS = 6'h1F;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = KIND_LINK;
  logic [7:0] link_byte = 8'h00;
  logic [7:0] key_code = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] response_byte;

  // Responder state as the bench sees it
  logic [7:0] nkc_value = 8'h00;
  mode_t link_mode = MODE_IDLE;
  logic [7:0] held_key = 8'h00;
  logic key_waiting = 1'b0;
  logic [5:0] byte_pos = 6'd0;
  clock_time_t now_time = {8'd0, 8'd0, 8'd0, DAY_RESET, MONTH_RESET, YEAR_RESET};
  clock_time_t snap_time = '0;
  clock_time_t captured = '0;

  logic [7:0] expected_bytes[$];
  int fail_count = 0;
  int items_sent = 0;
  int responses_seen = 0;
  int frames_started = 0;
  int writes_applied = 0;
  int ticks_sent = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  link_command_responder_with_clock DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .link_byte(link_byte),
    .key_code(key_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .response_byte(response_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               expected_bytes.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    if (fail_count < REPORT_MAX) $display("[%0t] %s", $realtime, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
  endfunction

  // ASCII character at one position of the clock frame
  function automatic logic [7:0] frame_char(input clock_time_t snap, input logic [5:0] pos);
    logic [7:0] v;
    if (pos >= FIELD_FIRST_POS && pos <= FIELD_LAST_POS) begin
      case ((pos - FIELD_FIRST_POS) >> 1)
        6'd0: v = snap.sec;
        6'd1: v = snap.min;
        6'd2: v = snap.hour;
        6'd3: v = snap.day;
        default: v = snap.month;
      endcase
      if (pos[0] == 1'b0) return ASCII_ZERO + 8'((int'(v) / 10) % 10);
      return ASCII_ZERO + 8'(int'(v) % 10);
    end
    if (pos == YEAR_HI_POS) return ASCII_ZERO + {4'h0, snap.year[7:4]};
    if (pos == YEAR_LO_POS) return ASCII_ZERO + {4'h0, snap.year[3:0]};
    return ASCII_ZERO;
  endfunction

  // One-second tick; the date stays put
  task automatic advance_clock();
    now_time.sec = now_time.sec + 8'd1;
    if (now_time.sec >= SEC_LIMIT) begin
      now_time.sec = 8'd0;
      now_time.min = now_time.min + 8'd1;
      if (now_time.min >= MIN_LIMIT) begin
        now_time.min = 8'd0;
        now_time.hour = now_time.hour + 8'd1;
        if (now_time.hour >= HOUR_LIMIT) now_time.hour = 8'd0;
      end
    end
  endtask

  // Update the state for one accepted item and queue its response, if any
  task automatic predict_item(input logic [1:0] k, input logic [7:0] lb, input logic [7:0] kc);
    logic [7:0] resp;
    if (k == KIND_KEY) begin
      if (kc != 8'h00) begin
        held_key = kc;
        key_waiting = 1'b1;
      end
    end else if (k == KIND_TICK) begin
      advance_clock();
      ticks_sent++;
    end else if (k == KIND_LINK) begin
      resp = nkc_value;
      case (link_mode)
        MODE_IDLE: begin
          if (lb == CMD_INIT) begin
            resp = INIT_REPLY;
            link_mode = MODE_ACTIVE;
          end
        end
        MODE_ACTIVE: begin
          if (lb == CMD_POLL) begin
            resp = key_waiting ? held_key : nkc_value;
            key_waiting = 1'b0;
          end else if (lb == CMD_READ) begin
            snap_time = now_time;
            resp = frame_char(snap_time, 6'd0);
            byte_pos = 6'd1;
            link_mode = MODE_READ;
            frames_started++;
          end else if (lb == CMD_WRITE) begin
            byte_pos = 6'd0;
            resp = WRITE_ACK;
            link_mode = MODE_WRITE;
          end else if (lb == CMD_INIT) begin
            resp = INIT_REPLY;
          end
        end
        MODE_READ: begin
          resp = frame_char(snap_time, byte_pos);
          byte_pos = byte_pos + 6'd1;
          if (byte_pos >= FRAME_LEN) link_mode = MODE_ACTIVE;
        end
        default: begin
          if (byte_pos >= CAP_FIRST && byte_pos <= CAP_LAST) begin
            case (byte_pos - CAP_FIRST)
              6'd0: captured.sec = lb;
              6'd1: captured.min = lb;
              6'd2: captured.hour = lb;
              6'd3: captured.day = lb;
              default: captured.month = lb;
            endcase
          end else if (byte_pos == CAP_YEAR) begin
            captured.year = lb;
          end
          byte_pos = byte_pos + 6'd1;
          // Apply the captured fields once the payload is complete
          if (byte_pos >= WRITE_LEN) begin
            now_time.sec = bcd_to_bin(captured.sec);
            now_time.min = bcd_to_bin(captured.min);
            now_time.hour = bcd_to_bin(captured.hour);
            now_time.day = bcd_to_bin(captured.day & DAY_MASK);
            now_time.month = bcd_to_bin(captured.month & MONTH_MASK);
            now_time.year = captured.year;
            link_mode = MODE_ACTIVE;
            writes_applied++;
          end
        end
      endcase
      expected_bytes.push_back(resp);
    end
  endtask

  // ------------------------------------------------------------------ checking

  always @(posedge clk) begin : check_responses
    logic [7:0] want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      responses_seen++;
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected response 0x%02h", response_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (response_byte !== want)
          note_failure($sformatf("response_byte mismatch: expected 0x%02h, got 0x%02h",
                                 want, response_byte));
      end
    end
  end

  // Output stalls: runs of ready broken by mostly short stalls
  initial begin : drive_out_ready
    int run_len;
    int stall_len;
    int r;
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (run_len) begin
        @(posedge clk);
        out_ready <= 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 65) stall_len = $urandom_range(1, 3);
      else if (r < 93) stall_len = $urandom_range(4, 9);
      else stall_len = $urandom_range(20, 40);
      repeat (stall_len) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ stimulus

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Hold one item on the input until its transfer, then predict it
  task automatic send_item(input logic [1:0] k, input logic [7:0] lb, input logic [7:0] kc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    link_byte <= lb;
    key_code <= kc;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_item(k, lb, kc);
    items_sent++;
  endtask

  task automatic send_link(input logic [7:0] lb);
    send_item(KIND_LINK, lb, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_key(input logic [7:0] kc);
    send_item(KIND_KEY, 8'($urandom_range(0, 255)), kc);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and let every response drain
  task automatic wait_for_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_no_key_code(input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    nkc_value = value;
  endtask

  function automatic logic [7:0] random_key();
    if ($urandom_range(0, 9) == 0) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] random_link_byte();
    case ($urandom_range(0, 9))
      0: return CMD_INIT;
      1: return CMD_POLL;
      2: return CMD_READ;
      3: return CMD_WRITE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] random_bcd(input int lo, input int hi);
    int v;
    v = $urandom_range(lo, hi);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic clock_time_t random_clock();
    clock_time_t t;
    int r;
    r = $urandom_range(0, 99);
    t.year = 8'($urandom_range(0, 255));
    if (r < 10) begin
      // raw bytes, nibbles above nine included
      t.sec = 8'($urandom_range(0, 255));
      t.min = 8'($urandom_range(0, 255));
      t.hour = 8'($urandom_range(0, 255));
      t.day = 8'($urandom_range(0, 255));
      t.month = 8'($urandom_range(0, 255));
    end else if (r < 40) begin
      // close to a minute, hour or day rollover
      t.sec = random_bcd(55, 59);
      t.min = ($urandom_range(0, 1) == 0) ? 8'h59 : random_bcd(0, 59);
      t.hour = ($urandom_range(0, 1) == 0) ? 8'h23 : random_bcd(0, 23);
      t.day = random_bcd(1, 31);
      t.month = random_bcd(1, 12);
    end else begin
      t.sec = random_bcd(0, 59);
      t.min = random_bcd(0, 59);
      t.hour = random_bcd(0, 23);
      t.day = random_bcd(1, 31);
      t.month = random_bcd(1, 12);
    end
    return t;
  endfunction

  function automatic logic [7:0] payload_byte(input clock_time_t raw, input logic [5:0] pos);
    case (pos)
      CAP_FIRST: return raw.sec;
      CAP_FIRST + 6'd1: return raw.min;
      CAP_FIRST + 6'd2: return raw.hour;
      CAP_FIRST + 6'd3: return raw.day;
      CAP_LAST: return raw.month;
      CAP_YEAR: return raw.year;
      default: return random_link_byte();
    endcase
  endfunction

  // Occasionally slip a key, tick or unused kind between link bytes
  task automatic maybe_side_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) send_tick();
    else if (r < 14) send_key(random_key());
    else if (r < 16) send_item(KIND_UNUSED, random_link_byte(), random_key());
  endtask

  // Close any frame read or clock write left open
  task automatic finish_sequence();
    while (link_mode == MODE_READ || link_mode == MODE_WRITE) send_link(random_link_byte());
  endtask

  task automatic run_clock_read();
    finish_sequence();
    send_link(CMD_READ);
    repeat (int'(FRAME_LEN) - 1) begin
      maybe_side_event();
      send_link(random_link_byte());
    end
  endtask

  task automatic run_clock_write(input clock_time_t raw);
    finish_sequence();
    send_link(CMD_WRITE);
    for (int i = 0; i < int'(WRITE_LEN); i++) begin
      maybe_side_event();
      send_link(payload_byte(raw, 6'(i)));
    end
  endtask

  // ---------------------------------------------------------------- test tasks

  // Idle mode answers everything but init with the no-key code
  task automatic test_idle_and_init();
    send_link(8'h00);
    send_link(8'hFF);
    send_item(KIND_UNUSED, CMD_INIT, 8'hFF);
    send_key(8'h00);
    send_key(8'h5A);
    send_link(CMD_POLL);
    send_link(CMD_READ);
    send_link(CMD_INIT);
    send_link(CMD_INIT);
    send_link(CMD_POLL);
  endtask

  // Pending key returned once, zero key ignored, unknown commands
  task automatic test_keys_and_poll();
    send_link(CMD_POLL);
    send_key(8'hFF);
    send_key(8'h00);
    send_link(CMD_POLL);
    send_link(CMD_POLL);
    send_key(8'h01);
    send_key(8'h80);
    send_link(CMD_POLL);
    send_link(8'h00);
    send_link(8'hFF);
    send_tick();
    send_item(KIND_UNUSED, 8'hFF, 8'hFF);
  endtask

  // Frame of the running clock, with ticks between snapshots
  task automatic test_clock_read();
    run_clock_read();
    repeat (3) send_tick();
    run_clock_read();
  endtask

  // BCD load at the edges, then ticks through every rollover
  task automatic test_clock_write();
    clock_time_t t;
    t.sec = 8'h58;
    t.min = 8'h59;
    t.hour = 8'h23;
    t.day = 8'h31;
    t.month = 8'h12;
    t.year = 8'hFF;
    run_clock_write(t);
    repeat (3) send_tick();
    run_clock_read();
    // out-of-range fields wrap on the next tick
    t.sec = 8'hFF;
    t.min = 8'h59;
    t.hour = 8'hFF;
    t.day = 8'hFF;
    t.month = 8'hFF;
    t.year = 8'h00;
    run_clock_write(t);
    run_clock_read();
    send_tick();
    run_clock_read();
  endtask

  // Mostly well-formed reads, writes and polls with random content, plus noise
  task automatic test_random_traffic(input int item_budget);
    int stop_at;
    int r;
    int n;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      finish_sequence();
      r = $urandom_range(0, 99);
      if (r < 25) begin
        run_clock_read();
      end else if (r < 45) begin
        run_clock_write(random_clock());
        repeat ($urandom_range(0, 4)) send_tick();
      end else if (r < 70) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) send_key(random_key());
          else send_link(CMD_POLL);
        end
      end else if (r < 85) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 8);
        repeat (n) send_tick();
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_item(2'($urandom_range(0, 3)), random_link_byte(), random_key());
      end
    end
    no_gaps = 1'b0;
  endtask

  // ------------------------------------------------------------------ sequence

  initial begin : run_tests
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_init();
    test_keys_and_poll();
    wait_for_responses();

    set_no_key_code(8'hFF);
    test_keys_and_poll();
    test_clock_read();
    test_clock_write();
    wait_for_responses();

    set_no_key_code(8'h00);
    test_random_traffic(60);
    wait_for_responses();

    set_no_key_code(8'hFF);
    test_random_traffic(60);
    wait_for_responses();

    set_no_key_code(8'($urandom_range(1, 254)));
    test_random_traffic(60);
    wait_for_responses();

    set_no_key_code(8'($urandom_range(0, 255)));
    test_random_traffic(60);
    wait_for_responses();

    if (expected_bytes.size() != 0)
      note_failure($sformatf("%0d responses never arrived", expected_bytes.size()));
    $display("Sent %0d items (%0d ticks); checked %0d responses over %0d clock frames",
             items_sent, ticks_sent, responses_seen, frames_started);
    $display("and %0d clock writes; %0d mismatches", writes_applied, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/lcr_pkg.sv
src/lcr_clock.sv
src/lcr_frame.sv
src/link_command_responder_with_clock.sv
src/lcr_checker.sv
tb/sv/tb.sv
